/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OTI_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define OTI_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/oti_pkg.sv */
// ----------------------------------------------------------------------------
// oti_pkg
// Types, constants and helpers for the orbit table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package oti_pkg;

  localparam int MaxSamples = 1024;
  localparam int SampleW    = 10;
  localparam int SlotW      = 4;
  localparam int AddrW      = SampleW + SlotW;
  localparam int TimeW      = 48;
  localparam int ValW       = 64;
  localparam int ProdW      = ValW + TimeW;
  localparam int CountW     = 11;
  localparam int CraftCount = 3;
  localparam int LinkCount  = 6;
  localparam int LerpLat    = 2 + ValW;

  localparam logic [SlotW-1:0] SlotPos  = 4'd0;
  localparam logic [SlotW-1:0] SlotNorm = 4'd3;
  localparam logic [SlotW-1:0] SlotTrav = 4'd9;

  localparam logic [6:0] Link12 = 7'd12;
  localparam logic [6:0] Link23 = 7'd23;
  localparam logic [6:0] Link31 = 7'd31;
  localparam logic [6:0] Link13 = 7'd13;
  localparam logic [6:0] Link32 = 7'd32;
  localparam logic [6:0] Link21 = 7'd21;
  localparam logic [6:0] CraftLast = 7'd3;

  typedef enum logic {CMD_WRITE, CMD_QUERY} cmd_e;
  typedef enum logic [1:0] {SEL_POS, SEL_NORM, SEL_TRAV, SEL_NONE} sel_e;
  typedef enum logic [1:0] {ST_OK, ST_RANGE, ST_CODE} status_e;
  typedef enum logic {REG_SAMPLE_STEP, REG_SAMPLE_COUNT} cfg_reg_e;

  typedef struct packed {
    logic                valid;
    cmd_e                cmd;
    logic [1:0]          sel;
    logic [6:0]          code;
    logic [SampleW-1:0]  ws;
    logic [2:0]          we;
    logic [1:0]          wa;
    logic [ValW-1:0]     wv;
  } meta_t;

  // {hit, index}
  function automatic logic [3:0] link_lookup(logic [6:0] code);
    logic [3:0] r;
    case (code)
      Link12:  r = 4'b1000;
      Link23:  r = 4'b1001;
      Link31:  r = 4'b1010;
      Link13:  r = 4'b1011;
      Link32:  r = 4'b1100;
      Link21:  r = 4'b1101;
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/oti_req_if.sv */
// ----------------------------------------------------------------------------
// oti_req_if
// Request channel: table writes and interpolation queries.
// ----------------------------------------------------------------------------
`default_nettype none

interface oti_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [1:0]         table_sel;
  logic [47:0]        query_time;
  logic [6:0]         entity_code;
  logic [9:0]         write_sample;
  logic [2:0]         write_entity;
  logic [1:0]         write_axis;
  logic signed [63:0] write_value;

  modport source (output valid, cmd, table_sel, query_time, entity_code, write_sample,
                  write_entity, write_axis, write_value, input ready);
  modport sink (input valid, cmd, table_sel, query_time, entity_code, write_sample,
                write_entity, write_axis, write_value, output ready);
endinterface

`default_nettype wire

/* rtl/oti_rsp_if.sv */
// ----------------------------------------------------------------------------
// oti_rsp_if
// Response channel: interpolated components and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface oti_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] out_x;
  logic signed [63:0] out_y;
  logic signed [63:0] out_z;
  logic [1:0]         status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

`default_nettype wire

/* rtl/oti_divider.sv */
// ----------------------------------------------------------------------------
// oti_divider
// Pipelined restoring divider, one quotient bit per stage: window and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module oti_divider (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire oti_pkg::meta_t       meta_i,
  input  wire logic [47:0]          time_i,
  input  wire logic [47:0]          step_i,
  output oti_pkg::meta_t            meta_o,
  output logic [47:0]               quot_o,
  output logic [47:0]               rem_o
);
  import oti_pkg::*;

  meta_t            meta_q [TimeW];
  logic [TimeW-1:0] rem_q  [TimeW];
  logic [TimeW-1:0] dq_q   [TimeW];

  for (genvar k = 0; k < TimeW; k++) begin : g_st
    logic [TimeW-1:0] r_in, d_in;
    meta_t            m_in;
    logic [TimeW:0]   tmp, sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = time_i;
      assign m_in = meta_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = dq_q[k-1];
      assign m_in = meta_q[k-1];
    end

    assign tmp = {r_in, d_in[TimeW-1]};
    assign sub = tmp - {1'b0, step_i};
    assign ge  = tmp >= {1'b0, step_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[k] <= '0;
      end else if (en_i) begin
        meta_q[k] <= m_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? sub[TimeW-1:0] : tmp[TimeW-1:0];
        dq_q[k]  <= {d_in[TimeW-2:0], ge};
      end
    end
  end

  assign meta_o = meta_q[TimeW-1];
  assign quot_o = dq_q[TimeW-1];
  assign rem_o  = rem_q[TimeW-1];

endmodule

`default_nettype wire

/* rtl/oti_table_mem.sv */
// ----------------------------------------------------------------------------
// oti_table_mem
// Sample storage, one word per sample slot holding all three axes: one write
// port with an axis select, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module oti_table_mem (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [1:0]       wsel_i,
  input  wire logic [13:0]      waddr_i,
  input  wire logic [63:0]      wdata_i,
  input  wire logic [13:0]      raddr_a_i,
  input  wire logic [13:0]      raddr_b_i,
  output logic [2:0][63:0]      rdata_a_o,
  output logic [2:0][63:0]      rdata_b_o
);
  import oti_pkg::*;

  logic [2:0][ValW-1:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[waddr_i][wsel_i] <= wdata_i;
      end
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/oti_lerp_lane.sv */
// ----------------------------------------------------------------------------
// oti_lerp_lane
// down + sgn(up-down)*trunc(|up-down|*rem/step): split multiply, then a
// pipelined restoring divide of the product, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module oti_lerp_lane (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] down_i,
  input  wire logic [63:0] up_i,
  input  wire logic [47:0] rem_i,
  input  wire logic [47:0] step_i,
  output logic [63:0]      res_o
);
  import oti_pkg::*;

  logic            rising, rise_a_q, rise_b_q;
  logic [ValW-1:0] mag, down_a_q, down_b_q;
  logic [63:0]     p0_q, p2_q;
  logic [47:0]     p1_q, p3_q;
  logic [ProdW-1:0] prod_q;

  assign rising = $signed(up_i) >= $signed(down_i);
  assign mag    = rising ? up_i - down_i : down_i - up_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rise_a_q <= rising;
      down_a_q <= down_i;
      p0_q     <= mag[31:0] * rem_i[31:0];
      p1_q     <= mag[31:0] * rem_i[47:32];
      p2_q     <= mag[63:32] * rem_i[31:0];
      p3_q     <= mag[63:32] * rem_i[47:32];
      rise_b_q <= rise_a_q;
      down_b_q <= down_a_q;
      prod_q   <= ProdW'(p0_q) + (ProdW'(p1_q) << 32) + (ProdW'(p2_q) << 32)
                + (ProdW'(p3_q) << 64);
    end
  end

  // product < 2^64 * step, so the top bits start below the divisor
  logic [TimeW-1:0] r_q    [ValW];
  logic [ValW-1:0]  dq_q   [ValW];
  logic [ValW-1:0]  dn_q   [ValW];
  logic             rs_q   [ValW];

  for (genvar k = 0; k < ValW; k++) begin : g_st
    logic [TimeW-1:0] r_in;
    logic [ValW-1:0]  d_in, dn_in;
    logic             rs_in;
    logic [TimeW:0]   tmp, sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in  = prod_q[ProdW-1:ValW];
      assign d_in  = prod_q[ValW-1:0];
      assign dn_in = down_b_q;
      assign rs_in = rise_b_q;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign d_in  = dq_q[k-1];
      assign dn_in = dn_q[k-1];
      assign rs_in = rs_q[k-1];
    end

    assign tmp = {r_in, d_in[ValW-1]};
    assign sub = tmp - {1'b0, step_i};
    assign ge  = tmp >= {1'b0, step_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? sub[TimeW-1:0] : tmp[TimeW-1:0];
        dq_q[k] <= {d_in[ValW-2:0], ge};
        dn_q[k] <= dn_in;
        rs_q[k] <= rs_in;
      end
    end
  end

  assign res_o = rs_q[ValW-1] ? dn_q[ValW-1] + dq_q[ValW-1] : dn_q[ValW-1] - dq_q[ValW-1];

endmodule

`default_nettype wire

/* rtl/orbit_table_linear_interp.sv */
// ----------------------------------------------------------------------------
// orbit_table_linear_interp
// Sample tables for positions, link normals and light travel times, with
// piecewise linear interpolation between neighboring samples.
// ----------------------------------------------------------------------------
// One request beat per cycle while ready is high, writes and queries alike;
// a query's result passes 48 divider stages for the window (the first at
// the taking edge), one decode stage, one table read, 66 interpolation
// stages and the output register. Writes travel the same pipe, so
// every query sees exactly the writes taken before it. A two-beat output
// buffer lets the request side keep going while a result waits; the pipe
// stalls only when both are full.
`default_nettype none

`include "assert_macros.svh"

module orbit_table_linear_interp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [47:0] cfg_wdata_i,
  oti_req_if.sink          req_i,
  oti_rsp_if.source        rsp_o
);
  import oti_pkg::*;

  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    logic               travel;
    status_e            status;
    logic [AddrW-1:0]   rd_d;
    logic [AddrW-1:0]   rd_u;
    logic               wen;
    logic [AddrW-1:0]   waddr;
    logic [1:0]         wa;
    logic [ValW-1:0]    wv;
    logic [TimeW-1:0]   rem;
  } chk_t;

  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic             travel;
    status_e          status;
    logic [TimeW-1:0] rem;
  } mst_t;

  typedef struct packed {
    logic    valid;
    cmd_e    cmd;
    logic    travel;
    status_e status;
  } sb_t;

  typedef struct packed {
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
    logic [ValW-1:0] z;
    status_e         status;
  } res_t;

  logic [TimeW-1:0]  step_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 48'd65536;
      count_q <= CountW'(MaxSamples);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SAMPLE_STEP:  step_q  <= cfg_wdata_i;
        REG_SAMPLE_COUNT: count_q <= cfg_wdata_i[CountW-1:0];
        default:          step_q  <= step_q;
      endcase
    end
  end

  logic en;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  res_t out_q, out_d, skid_q, skid_d;

  assign en          = !skid_valid_q;
  assign req_i.ready = en;

  // window divider
  meta_t            meta_in, meta_dv;
  logic [TimeW-1:0] quot, rem;

  always_comb begin
    meta_in.valid = req_i.valid && en;
    meta_in.cmd   = cmd_e'(req_i.cmd);
    meta_in.sel   = req_i.table_sel;
    meta_in.code  = req_i.entity_code;
    meta_in.ws    = req_i.write_sample;
    meta_in.we    = req_i.write_entity;
    meta_in.wa    = req_i.write_axis;
    meta_in.wv    = req_i.write_value;
  end

  oti_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta_in),
    .time_i (req_i.query_time),
    .step_i (step_q),
    .meta_o (meta_dv),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // range check, code decode, addresses
  logic [CountW-1:0] cnt, cnt_m2;
  logic              oor, hit;
  logic [2:0]        idx;
  logic [3:0]        lk;
  logic [SlotW-1:0]  slot, wslot;
  logic              wok;
  chk_t              chk_d, chk_q;

  always_comb begin
    cnt    = (count_q > CountW'(MaxSamples)) ? CountW'(MaxSamples) : count_q;
    cnt_m2 = cnt - CountW'(2);
    oor    = (step_q == '0) || (cnt < CountW'(2)) || (quot > TimeW'(cnt_m2));
    lk     = link_lookup(meta_dv.code);
    hit    = 1'b0;
    idx    = '0;
    slot   = SlotPos;
    wslot  = SlotPos;
    wok    = 1'b0;
    case (sel_e'(meta_dv.sel))
      SEL_POS: begin
        hit   = (meta_dv.code != '0) && (meta_dv.code <= CraftLast);
        idx   = meta_dv.code[2:0] - 3'd1;
        slot  = SlotPos + SlotW'(idx);
        wslot = SlotPos + SlotW'(meta_dv.we);
        wok   = (meta_dv.we < 3'(CraftCount)) && (meta_dv.wa < 2'd3);
      end
      SEL_NORM: begin
        hit   = lk[3];
        idx   = lk[2:0];
        slot  = SlotNorm + SlotW'(idx);
        wslot = SlotNorm + SlotW'(meta_dv.we);
        wok   = (meta_dv.we < 3'(LinkCount)) && (meta_dv.wa < 2'd3);
      end
      SEL_TRAV: begin
        hit   = lk[3];
        idx   = lk[2:0];
        slot  = SlotTrav + SlotW'(idx);
        wslot = SlotTrav + SlotW'(meta_dv.we);
        wok   = (meta_dv.we < 3'(LinkCount)) && (meta_dv.wa == 2'd0);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    chk_d.valid  = meta_dv.valid;
    chk_d.cmd    = meta_dv.cmd;
    chk_d.travel = sel_e'(meta_dv.sel) == SEL_TRAV;
    chk_d.status = oor ? ST_RANGE : (hit ? ST_OK : ST_CODE);
    chk_d.rd_d   = {quot[SampleW-1:0], slot};
    chk_d.rd_u   = {quot[SampleW-1:0] + SampleW'(1), slot};
    chk_d.wen    = meta_dv.valid && (meta_dv.cmd == CMD_WRITE) && wok;
    chk_d.waddr  = {meta_dv.ws, wslot};
    chk_d.wa     = meta_dv.wa;
    chk_d.wv     = meta_dv.wv;
    chk_d.rem    = rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= '0;
    end else if (en) begin
      chk_q <= chk_d;
    end
  end

  // sample table, all three axes in one word
  logic [2:0][ValW-1:0] rd_a, rd_b;
  logic [ValW-1:0]      lane [3];
  mst_t                 mst_q;

  oti_table_mem u_mem (
    .clk_i     (clk_i),
    .en_i      (en),
    .we_i      (chk_q.wen),
    .wsel_i    (chk_q.wa),
    .waddr_i   (chk_q.waddr),
    .wdata_i   (chk_q.wv),
    .raddr_a_i (chk_q.rd_d),
    .raddr_b_i (chk_q.rd_u),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  for (genvar a = 0; a < 3; a++) begin : g_ax
    oti_lerp_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .down_i (rd_a[a]),
      .up_i   (rd_b[a]),
      .rem_i  (mst_q.rem),
      .step_i (step_q),
      .res_o  (lane[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mst_q <= '0;
    end else if (en) begin
      mst_q.valid  <= chk_q.valid;
      mst_q.cmd    <= chk_q.cmd;
      mst_q.travel <= chk_q.travel;
      mst_q.status <= chk_q.status;
      mst_q.rem    <= chk_q.rem;
    end
  end

  // sideband alongside the lanes
  sb_t sb_q [LerpLat];

  for (genvar s = 0; s < LerpLat; s++) begin : g_sb
    sb_t sb_in;

    if (s == 0) begin : g_head
      assign sb_in = '{mst_q.valid, mst_q.cmd, mst_q.travel, mst_q.status};
    end else begin : g_tail
      assign sb_in = sb_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_q[s] <= '0;
      end else if (en) begin
        sb_q[s] <= sb_in;
      end
    end
  end

  // output register plus skid
  sb_t  fin_sb;
  logic fin_valid, take, ok;
  res_t fin;

  assign fin_sb    = sb_q[LerpLat-1];
  assign fin_valid = fin_sb.valid && (fin_sb.cmd == CMD_QUERY);
  assign take      = out_valid_q && rsp_o.ready;
  assign ok        = fin_sb.status == ST_OK;

  always_comb begin
    fin.x      = ok ? lane[0] : '0;
    fin.y      = (ok && !fin_sb.travel) ? lane[1] : '0;
    fin.z      = (ok && !fin_sb.travel) ? lane[2] : '0;
    fin.status = fin_sb.status;

    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      out_valid_d  = skid_valid_q;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
    if (en && fin_valid) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_d       = fin;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.out_x  = out_q.x;
  assign rsp_o.out_y  = out_q.y;
  assign rsp_o.out_z  = out_q.z;
  assign rsp_o.status = out_q.status;

  `OTI_ASSERT_IMP(a_skid_has_head, skid_valid_q, out_valid_q, "skid beat without head beat")
  `OTI_ASSERT_IMP(a_err_zero, out_valid_q && (out_q.status != ST_OK), (out_q.x == '0) && (out_q.y == '0) && (out_q.z == '0), "nonzero data on error status")
  `OTI_ASSERT_NXT(a_skid_hold, skid_valid_q && !rsp_o.ready, skid_valid_q, "skid beat dropped")

endmodule

`default_nettype wire
